### rtl/rsm_pkg.sv
`default_nettype none
package rsm_pkg;

	typedef logic [4:0] step_t;

	localparam step_t ST_IDLE  = 5'd0;
	localparam step_t ST_RMAG  = 5'd1;
	localparam step_t ST_RMUL  = 5'd2;
	localparam step_t ST_RADJ  = 5'd3;
	localparam step_t ST_RATE  = 5'd4;
	localparam step_t ST_PHASE = 5'd5;
	localparam step_t ST_ROM   = 5'd6;
	localparam step_t ST_PROD  = 5'd7;
	localparam step_t ST_MS    = 5'd8;
	localparam step_t ST_DMUL  = 5'd9;
	localparam step_t ST_DSAT  = 5'd10;
	localparam step_t ST_LRD   = 5'd11;
	localparam step_t ST_LINT  = 5'd12;
	localparam step_t ST_LSUM  = 5'd13;
	localparam step_t ST_LWG   = 5'd14;
	localparam step_t ST_LWET  = 5'd15;
	localparam step_t ST_LMIX  = 5'd16;
	localparam step_t ST_LTOT  = 5'd17;
	localparam step_t ST_DONE  = 5'd18;

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_SPEED_FAST = 3'd0;
	localparam reg_idx_t REG_RAMP_ALPHA = 3'd1;
	localparam reg_idx_t REG_DEPTH      = 3'd2;
	localparam reg_idx_t REG_MIX        = 3'd3;
	localparam reg_idx_t REG_SLOW_STEP  = 3'd4;
	localparam reg_idx_t REG_FAST_STEP  = 3'd5;
	localparam reg_idx_t REG_SPMS       = 3'd6;

	localparam logic [23:0] RST_RAMP_ALPHA = 24'd27962;
	localparam logic [15:0] RST_DEPTH      = 16'd22938;
	localparam logic [15:0] RST_MIX        = 16'd32768;
	localparam logic [23:0] RST_SLOW_STEP  = 24'd71583;
	localparam logic [23:0] RST_FAST_STEP  = 24'd581610;
	localparam logic [15:0] RST_SPMS       = 16'd12288;

	typedef struct packed {
		logic        speed_fast;
		logic [23:0] ramp_alpha;
		logic [15:0] depth;
		logic [15:0] mix;
		logic [23:0] slow_step;
		logic [23:0] fast_step;
		logic [15:0] samples_per_ms;
	} cfg_t;

	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
	localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210};

	// Sine of a turn fraction up to a quarter turn, Q32 in and Q30 out, by a Taylor series.
	function automatic logic [63:0] quarter_sin(input logic [63:0] u);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		x = (u * TWO_PI_Q30) >> 32;
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		if (sum > 64'd1073741824) begin
			sum = 64'd1073741824;
		end
		return sum;
	endfunction

	// Table entry k of a sine table with 2**lg entries, scaled by 32768.
	function automatic logic signed [16:0] sine_val(input int k, input int lg);
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] s;
		logic [16:0] v;
		q = 64'(k) << (32 - lg);
		r = q & 64'h3FFF_FFFF;
		if (q[30]) begin
			s = quarter_sin(64'h4000_0000 - r);
		end else begin
			s = quarter_sin(r);
		end
		v = 17'((s + 64'd16384) >> 15);
		return q[31] ? -$signed(v) : $signed(v);
	endfunction

endpackage
`default_nettype wire

### rtl/rsm_rotor.sv
`default_nettype none
module rsm_rotor #(
	parameter int LINE_DEPTH       = 1024,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  rsm_pkg::step_t                 step,
	input  rsm_pkg::cfg_t                  cfg,
	output logic [$clog2(LINE_DEPTH)+16:0] delay,
	output logic [15:0]                    gain
);
	import rsm_pkg::*;

	localparam int SL = $clog2(SINE_TABLE_DEPTH);
	localparam int LW = $clog2(LINE_DEPTH);
	localparam int DW = LW + 17;
	localparam logic [31:0] LIMIT = 32'(LINE_DEPTH) << 16;

	logic signed [16:0] rom [SINE_TABLE_DEPTH];

	for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
		assign rom[k] = sine_val(k, SL);
	end

	logic [47:0]        rate_q;
	logic [31:0]        phase_q;
	logic [47:0]        mag_s1;
	logic               ge_s1;
	logic [55:0]        phi_s2;
	logic [23:0]        plo_s2;
	logic [40:0]        adj_q;
	logic signed [16:0] sin_q;
	logic signed [16:0] cos_q;
	logic [32:0]        gprod_q;
	logic signed [33:0] sprod_q;
	logic [15:0]        gain_q;
	logic [33:0]        ms_q;
	logic [49:0]        dprod_q;
	logic [DW-1:0]      delay_q;

	logic [47:0]        target;
	logic [SL-1:0]      sidx;
	logic [SL-1:0]      cidx;
	logic [16:0]        cmc;
	logic signed [36:0] s5;
	logic signed [36:0] msr;
	logic [31:0]        dq;

	assign target = {8'd0, cfg.speed_fast ? cfg.fast_step : cfg.slow_step, 16'd0};
	assign sidx = phase_q[31 -: SL];
	assign cidx = sidx + SL'(SINE_TABLE_DEPTH / 4);
	assign cmc = 17'(18'sd32768 - 18'(cos_q));
	assign s5 = 37'(sprod_q) + (37'(sprod_q) <<< 2);
	assign msr = (s5 >>> 1) + 37'sd3221225472;
	assign dq = 32'(dprod_q[49:22]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= {8'd0, RST_SLOW_STEP, 16'd0};
			phase_q <= '0;
		end else begin
			if (step == ST_RATE) begin
				rate_q <= ge_s1 ? rate_q + 48'(adj_q) : rate_q - 48'(adj_q);
			end
			if (step == ST_PHASE) begin
				phase_q <= phase_q + rate_q[47:16];
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (step)
			ST_RMAG: begin
				ge_s1 <= target >= rate_q;
				mag_s1 <= (target >= rate_q) ? target - rate_q : rate_q - target;
			end
			ST_RMUL: begin
				phi_s2 <= 56'(mag_s1[47:16]) * 56'(cfg.ramp_alpha);
				plo_s2 <= 24'((40'(mag_s1[15:0]) * 40'(cfg.ramp_alpha)) >> 16);
			end
			ST_RADJ: begin
				adj_q <= 41'((57'(phi_s2) + 57'(plo_s2)) >> 16);
			end
			ST_ROM: begin
				sin_q <= rom[sidx];
				cos_q <= rom[cidx];
			end
			ST_PROD: begin
				gprod_q <= 33'(cfg.depth) * 33'(cmc);
				sprod_q <= 34'($signed({1'b0, cfg.depth})) * 34'(sin_q);
			end
			ST_MS: begin
				gain_q <= 16'(17'd32768 - 17'(gprod_q[32:17]));
				if (msr < 37'sd536870912) begin
					ms_q <= 34'd536870912;
				end else begin
					ms_q <= msr[33:0];
				end
			end
			ST_DMUL: begin
				dprod_q <= 50'(ms_q) * 50'(cfg.samples_per_ms);
			end
			ST_DSAT: begin
				delay_q <= (dq > LIMIT) ? DW'(LIMIT) : DW'(dq);
			end
			default: begin
			end
		endcase
	end

	assign delay = delay_q;
	assign gain = gain_q;

endmodule
`default_nettype wire

### rtl/rsm_lane.sv
`default_nettype none
module rsm_lane #(
	parameter int LINE_DEPTH = 1024
) (
	input  wire                            clk,
	input  rsm_pkg::step_t                 step,
	input  wire  [15:0]                    mix,
	input  wire  [$clog2(LINE_DEPTH)-1:0]  wi,
	input  wire                            wrapped,
	input  wire  [$clog2(LINE_DEPTH)+16:0] delay,
	input  wire  [15:0]                    gain,
	input  wire  signed [23:0]             sample,
	output logic signed [23:0]             result
);
	import rsm_pkg::*;

	localparam int LW = $clog2(LINE_DEPTH);

	logic [23:0] mem [LINE_DEPTH];

	logic [23:0]        rd0_s1;
	logic [23:0]        rd1_s1;
	logic               v0_s1;
	logic               v1_s1;
	logic [15:0]        frac_s1;
	logic signed [41:0] pa_s2;
	logic signed [41:0] pb_s2;
	logic signed [41:0] interp_s3;
	logic signed [43:0] hg_s4;
	logic [31:0]        lg_s4;
	logic signed [43:0] wet_s5;
	logic signed [41:0] pdry_s6;
	logic signed [45:0] pwh_s6;
	logic [31:0]        pwl_s6;
	logic signed [23:0] res_q;

	logic [LW+15:0]     pos;
	logic [LW-1:0]      i0;
	logic [LW-1:0]      i1;
	logic signed [23:0] d0;
	logic signed [23:0] d1;
	logic [16:0]        w0;
	logic [16:0]        lgr;
	logic signed [17:0] dw;
	logic signed [63:0] total;
	logic signed [63:0] rnd;

	assign pos = {wi, 16'd0} - delay[LW+15:0];
	assign i0 = pos[LW+15:16];
	assign i1 = i0 + LW'(1);
	assign d0 = v0_s1 ? $signed(rd0_s1) : 24'sd0;
	assign d1 = v1_s1 ? $signed(rd1_s1) : 24'sd0;
	assign w0 = 17'd65536 - 17'(frac_s1);
	assign lgr = 17'((33'(lg_s4) + 33'd32768) >> 16);
	assign dw = 18'sd32768 - $signed({2'b00, mix});
	assign total = (64'(pdry_s6) <<< 15) + (64'(pwh_s6) <<< 16)
		+ 64'($signed({1'b0, pwl_s6})) + 64'sd536870912;
	assign rnd = total >>> 30;

	always_ff @(posedge clk) begin
		unique case (step)
			ST_LRD: begin
				rd0_s1 <= mem[i0];
				rd1_s1 <= mem[i1];
				v0_s1 <= wrapped || (i0 < wi);
				v1_s1 <= wrapped || (i1 < wi);
				frac_s1 <= pos[15:0];
			end
			ST_LINT: begin
				mem[wi] <= sample;
				pa_s2 <= 42'(d0) * 42'($signed({1'b0, w0}));
				pb_s2 <= 42'(d1) * 42'($signed({1'b0, frac_s1}));
			end
			ST_LSUM: begin
				interp_s3 <= pa_s2 + pb_s2;
			end
			ST_LWG: begin
				hg_s4 <= 44'($signed(interp_s3[41:16])) * 44'($signed({1'b0, gain}));
				lg_s4 <= 32'(interp_s3[15:0]) * 32'(gain);
			end
			ST_LWET: begin
				wet_s5 <= hg_s4 + 44'($signed({1'b0, lgr}));
			end
			ST_LMIX: begin
				pdry_s6 <= 42'(sample) * 42'(dw);
				pwh_s6 <= 46'($signed(wet_s5[43:16])) * 46'($signed({1'b0, mix}));
				pwl_s6 <= 32'(wet_s5[15:0]) * 32'(mix);
			end
			ST_LTOT: begin
				if (rnd > 64'sd8388607) begin
					res_q <= 24'sh7FFFFF;
				end else if (rnd < -64'sd8388608) begin
					res_q <= 24'sh800000;
				end else begin
					res_q <= rnd[23:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign result = res_q;

endmodule
`default_nettype wire

### rtl/rotary_speaker_modulator_top.sv
// Rotary speaker modulator: one stereo frame in, one stereo frame out.
// Frames enter on in_valid/in_ready with left_in and right_in, and leave on
// out_valid/out_ready with left_out and right_out. Registers are written on
// cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
// Each item runs, from acceptance until its result is valid, through a
// fixed sequence that first eases the rotor rate, advances the phase, reads
// the sine table and computes gain and delay on the shared rotor datapath,
// then runs the two channel lanes side by side (delay line read, linear
// interpolation, gain, dry/wet mix). One item is in flight at a time: a new
// item is accepted only once the last one has finished its sequence.
// The result waits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the following item holds in its last step
// until the output register is free.
// Reset restores the register defaults, the rotor rate and phase and the
// write position. The delay lines are not cleared: a fill mark treats every
// entry not yet written since reset as zero, so no clearing pass is needed.
`default_nettype none
module rotary_speaker_modulator_top #(
	parameter int LINE_DEPTH       = 1024,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire  signed [23:0] left_in,
	input  wire  signed [23:0] right_in,
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [23:0] left_out,
	output logic signed [23:0] right_out,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire  [2:0]         cfg_index,
	input  wire  [23:0]        cfg_data
);
	import rsm_pkg::*;

	localparam int LW = $clog2(LINE_DEPTH);

	step_t              step_q;
	cfg_t               cfg_q;
	logic [LW-1:0]      wi_q;
	logic               wrapped_q;
	logic               out_valid_q;
	logic signed [23:0] left_q;
	logic signed [23:0] right_q;
	logic signed [23:0] left_out_q;
	logic signed [23:0] right_out_q;

	logic [LW+16:0]     delay;
	logic [15:0]        gain;
	logic signed [23:0] left_res;
	logic signed [23:0] right_res;
	logic               finish;

	assign in_ready = (step_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign finish = (step_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_fast <= 1'b0;
			cfg_q.ramp_alpha <= RST_RAMP_ALPHA;
			cfg_q.depth <= RST_DEPTH;
			cfg_q.mix <= RST_MIX;
			cfg_q.slow_step <= RST_SLOW_STEP;
			cfg_q.fast_step <= RST_FAST_STEP;
			cfg_q.samples_per_ms <= RST_SPMS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SPEED_FAST: cfg_q.speed_fast <= cfg_data[0];
				REG_RAMP_ALPHA: cfg_q.ramp_alpha <= cfg_data;
				REG_DEPTH:      cfg_q.depth <= cfg_data[15:0];
				REG_MIX:        cfg_q.mix <= cfg_data[15:0];
				REG_SLOW_STEP:  cfg_q.slow_step <= cfg_data;
				REG_FAST_STEP:  cfg_q.fast_step <= cfg_data;
				REG_SPMS:       cfg_q.samples_per_ms <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			wi_q <= '0;
			wrapped_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step_q == ST_IDLE) begin
				if (in_valid) begin
					step_q <= ST_RMAG;
				end
			end else if (step_q == ST_DONE) begin
				if (finish) begin
					step_q <= ST_IDLE;
					wi_q <= wi_q + LW'(1);
					if (wi_q == LW'(LINE_DEPTH - 1)) begin
						wrapped_q <= 1'b1;
					end
				end
			end else begin
				step_q <= step_q + 5'd1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			left_q <= left_in;
			right_q <= right_in;
		end
		if (finish) begin
			left_out_q <= left_res;
			right_out_q <= right_res;
		end
	end

	rsm_rotor #(
		.LINE_DEPTH(LINE_DEPTH),
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_rotor (
		.clk(clk),
		.arst_n(arst_n),
		.step(step_q),
		.cfg(cfg_q),
		.delay(delay),
		.gain(gain)
	);

	rsm_lane #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_lane_left (
		.clk(clk),
		.step(step_q),
		.mix(cfg_q.mix),
		.wi(wi_q),
		.wrapped(wrapped_q),
		.delay(delay),
		.gain(gain),
		.sample(left_q),
		.result(left_res)
	);

	rsm_lane #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_lane_right (
		.clk(clk),
		.step(step_q),
		.mix(cfg_q.mix),
		.wi(wi_q),
		.wrapped(wrapped_q),
		.delay(delay),
		.gain(gain),
		.sample(right_q),
		.result(right_res)
	);

	assign out_valid = out_valid_q;
	assign left_out = left_out_q;
	assign right_out = right_out_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (step_q == ST_RMAG))
		else $error("accepted item did not start the sequence");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_DONE && out_valid_q && !out_ready) |=> (step_q == ST_DONE))
		else $error("finished item overwrote a waiting result");

	a_finish_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (out_valid_q && step_q == ST_IDLE))
		else $error("finished item not presented");

	a_wrap_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		wrapped_q |=> wrapped_q)
		else $error("fill mark cleared without reset");

	a_write_step: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (wi_q == $past(wi_q) + LW'(1)))
		else $error("write position did not advance once per item");

endmodule
`default_nettype wire

### sim/tb_top.sv
`default_nettype none
module tb_top;
	import rsm_pkg::*;

	localparam int LINE_LEN  = 1024;
	localparam int SINE_LEN  = 256;
	localparam int IDLE_LIMIT = 4000;
	localparam logic [63:0] TURN_Q30 = 64'd6746518852;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [23:0] left_in = '0;
	logic signed [23:0] right_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [23:0] left_out;
	logic signed [23:0] right_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	typedef struct {
		logic signed [23:0] left;
		logic signed [23:0] right;
	} frame_t;

	frame_t frames_due[$];
	int errors = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	cfg_t settings;
	logic [47:0] rotor_rate;
	logic [31:0] rotor_phase;
	int write_pos;
	longint line_mem [2][LINE_LEN];
	longint sine_tab [SINE_LEN];

	rotary_speaker_modulator_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.left_in(left_in), .right_in(right_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.left_out(left_out), .right_out(right_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [63:0] taylor_quarter_sine(logic [63:0] u);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		x = (u * TURN_Q30) >> 32;
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		if (sum > 64'd1073741824) begin
			sum = 64'd1073741824;
		end
		return sum;
	endfunction

	function automatic void build_sine_tab();
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] s;
		longint v;
		for (int k = 0; k < SINE_LEN; k++) begin
			q = (64'(k) << 32) / SINE_LEN;
			r = q & 64'h3FFF_FFFF;
			s = q[30] ? taylor_quarter_sine(64'h4000_0000 - r) : taylor_quarter_sine(r);
			v = longint'((s + 64'd16384) >> 15);
			sine_tab[k] = q[31] ? -v : v;
		end
	endfunction

	function automatic logic signed [23:0] mix_channel(int side, longint smp,
			longint delay_q16, longint gain);
		longint pos;
		longint frac;
		longint interp;
		longint wet;
		longint total;
		int i0;
		int i1;
		pos = (longint'(write_pos) << 16) - delay_q16;
		if (pos < 0) begin
			pos += longint'(LINE_LEN) << 16;
		end
		if (pos < 0) begin
			pos = 0;
		end
		i0 = int'((pos >>> 16) % LINE_LEN);
		i1 = (i0 + 1) % LINE_LEN;
		frac = pos & 64'hFFFF;
		interp = line_mem[side][i0] * (65536 - frac) + line_mem[side][i1] * frac;
		wet = (interp * gain + 32768) >>> 16;
		total = smp * 32768 * (32768 - longint'(settings.mix)) + wet * longint'(settings.mix);
		total = (total + (64'sd1 <<< 29)) >>> 30;
		line_mem[side][write_pos] = smp;
		if (total > 8388607) begin
			total = 8388607;
		end else if (total < -8388608) begin
			total = -8388608;
		end
		return total[23:0];
	endfunction

	function automatic frame_t rotor_frame(logic signed [23:0] l, logic signed [23:0] r);
		logic [47:0] target;
		logic [63:0] mag;
		logic [63:0] adj;
		int idx;
		longint s;
		longint c;
		longint gain;
		longint ms;
		longint delay_q16;
		frame_t f;
		target = {settings.speed_fast ? settings.fast_step : settings.slow_step, 16'h0};
		mag = (target >= rotor_rate) ? 64'(target - rotor_rate) : 64'(rotor_rate - target);
		adj = (((mag >> 16) * settings.ramp_alpha) +
			(((mag & 64'hFFFF) * settings.ramp_alpha) >> 16)) >> 16;
		rotor_rate = (target >= rotor_rate) ? rotor_rate + adj[47:0] : rotor_rate - adj[47:0];
		rotor_phase = rotor_phase + rotor_rate[47:16];
		idx = int'(rotor_phase[31:24]);
		s = sine_tab[idx];
		c = sine_tab[(idx + SINE_LEN / 4) % SINE_LEN];
		gain = 32768 - ((longint'(settings.depth) * (32768 - c)) >>> 17);
		ms = (64'sd3 <<< 30) + ((longint'(settings.depth) * s * 5) >>> 1);
		if (ms < (64'sd1 <<< 29)) begin
			ms = 64'sd1 <<< 29;
		end
		delay_q16 = (ms * longint'(settings.samples_per_ms)) >>> 22;
		if (delay_q16 > (longint'(LINE_LEN) << 16)) begin
			delay_q16 = longint'(LINE_LEN) << 16;
		end
		f.left = mix_channel(0, longint'(l), delay_q16, gain);
		f.right = mix_channel(1, longint'(r), delay_q16, gain);
		write_pos = (write_pos + 1) % LINE_LEN;
		return f;
	endfunction

	function automatic logic signed [23:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 24'sh7FFFFF;
			1: return -24'sh800000;
			2: return 24'($signed($urandom_range(0, 511)) - 256);
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_frame(logic signed [23:0] l, logic signed [23:0] r);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		left_in <= l;
		right_in <= r;
		do @(posedge clk); while (!in_ready);
		frames_due.insert(frames_due.size(), rotor_frame(l, r));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (frames_due.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic program_regs(cfg_t c);
		logic [23:0] vals [7];
		wait_idle();
		vals[REG_SPEED_FAST] = 24'(c.speed_fast);
		vals[REG_RAMP_ALPHA] = c.ramp_alpha;
		vals[REG_DEPTH] = 24'(c.depth);
		vals[REG_MIX] = 24'(c.mix);
		vals[REG_SLOW_STEP] = c.slow_step;
		vals[REG_FAST_STEP] = c.fast_step;
		vals[REG_SPMS] = 24'(c.samples_per_ms);
		for (int i = 0; i < 7; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		settings = c;
	endtask

	function automatic cfg_t make_cfg(logic fast, logic [23:0] alpha, logic [15:0] dep,
			logic [15:0] mx, logic [23:0] slow, logic [23:0] quick, logic [15:0] spms);
		cfg_t c;
		c.speed_fast = fast;
		c.ramp_alpha = alpha;
		c.depth = dep;
		c.mix = mx;
		c.slow_step = slow;
		c.fast_step = quick;
		c.samples_per_ms = spms;
		return c;
	endfunction

	task automatic test_sample_extremes();
		send_frame(24'sh7FFFFF, -24'sh800000);
		send_frame(-24'sh800000, 24'sh7FFFFF);
		send_frame(24'sh000000, 24'sh000000);
		send_frame(24'sh7FFFFF, 24'sh7FFFFF);
		send_frame(-24'sh800000, -24'sh800000);
		send_frame(24'sh555555, -24'sh555556);
	endtask

	task automatic test_delay_corners();
		// Zero delay reads the oldest stored sample; a maximal samples-per-ms value can saturate the delay.
		program_regs(make_cfg(1'b0, RST_RAMP_ALPHA, RST_DEPTH, 16'd16384, RST_SLOW_STEP,
			RST_FAST_STEP, 16'd0));
		repeat (4) send_frame(pick_sample(), pick_sample());
		program_regs(make_cfg(1'b1, 24'hFFFFFF, 16'd32768, 16'd32768, 24'd0, 24'hFFFFFF,
			16'hFFFF));
		repeat (4) send_frame(pick_sample(), pick_sample());
		program_regs(make_cfg(1'b0, 24'd0, 16'hFFFF, 16'hFFFF, 24'd0, 24'd0, 16'd1));
		repeat (4) send_frame(24'sh7FFFFF, -24'sh800000);
		program_regs(make_cfg(1'b0, 24'hFFFFFF, 16'd0, 16'd0, 24'hFFFFFF, 24'd0, RST_SPMS));
		repeat (4) send_frame(pick_sample(), pick_sample());
	endtask

	task automatic test_random_settings();
		cfg_t c;
		for (int p = 0; p < 9; p++) begin
			c.speed_fast = 1'($urandom);
			c.ramp_alpha = (p % 3 == 0) ? 24'($urandom) : 24'($urandom_range(0, 200000));
			c.depth = (p % 4 == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
			c.mix = (p % 4 == 1) ? 16'($urandom) : 16'($urandom_range(0, 32768));
			c.slow_step = (p % 2 == 0) ? 24'($urandom) : 24'($urandom_range(0, 200000));
			c.fast_step = (p % 2 == 1) ? 24'($urandom) : 24'($urandom_range(0, 2000000));
			c.samples_per_ms = (p % 3 == 2) ? 16'($urandom) : 16'($urandom_range(0, 16384));
			program_regs(c);
			repeat (120) send_frame(pick_sample(), pick_sample());
		end
	endtask

	task automatic test_steady_stream();
		program_regs(make_cfg(1'b1, RST_RAMP_ALPHA, RST_DEPTH, RST_MIX, RST_SLOW_STEP,
			RST_FAST_STEP, RST_SPMS));
		calm = 1'b1;
		repeat (200) send_frame(pick_sample(), pick_sample());
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!calm && arst_n && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 9);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		frame_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frames_due.size() == 0) begin
				$error("unexpected item: left_out %0d right_out %0d", left_out, right_out);
				errors++;
			end else begin
				want = frames_due.pop_front();
				if (left_out !== want.left) begin
					$error("left_out expected %0d actual %0d", want.left, left_out);
					errors++;
				end
				if (right_out !== want.right) begin
					$error("right_out expected %0d actual %0d", want.right, right_out);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles == IDLE_LIMIT) begin
			$display("rotary_speaker_modulator_top regression: fail");
			$finish;
		end
	end

	initial begin
		build_sine_tab();
		settings = make_cfg(1'b0, RST_RAMP_ALPHA, RST_DEPTH, RST_MIX, RST_SLOW_STEP,
			RST_FAST_STEP, RST_SPMS);
		rotor_rate = {RST_SLOW_STEP, 16'h0};
		rotor_phase = '0;
		write_pos = 0;
		for (int i = 0; i < LINE_LEN; i++) begin
			line_mem[0][i] = 0;
			line_mem[1][i] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_sample_extremes();
		test_delay_corners();
		test_random_settings();
		test_steady_stream();
		wait_idle();
		if (errors == 0) begin
			$display("rotary_speaker_modulator_top regression: pass");
		end else begin
			$display("rotary_speaker_modulator_top regression: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
